[rtl/integer_token_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer token parser
// Concurrent checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TOKEN_PARSER_TOP_MACROS_SVH
`define INTEGER_TOKEN_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define ITP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ITP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ITP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ITP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Types and character constants shared by the integer token parser.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_F     = 8'h46;  // 'F'

    localparam logic [3:0]  HEX_ALPHA_BASE = 4'd10;
    localparam logic [31:0] INT32_POS_MAG  = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_MAG  = 32'h8000_0000;
    localparam logic [1:0]  POS_MAX        = 2'd3;

    // One character transfer.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       signed_mode;
    } itp_item_t;

    // One result transfer.
    typedef struct packed {
        logic signed [32:0] value;
        logic               status;
    } itp_result_t;

    // Per-token parse state.
    typedef struct packed {
        logic [31:0] magnitude;
        logic [1:0]  position;
        logic        hex_base;
        logic        negative;
        logic        token_signed;
        logic        digit_seen;
        logic        error_seen;
    } itp_state_t;

endpackage

[rtl/itp_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_in_stage
// Input register for the character channel.
// ----------------------------------------------------------------------------
module itp_in_stage
    import itp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chr_valid,
    output logic      chr_stall,
    input  itp_item_t item_in,
    input  logic      advance,     // held item is consumed this cycle
    output logic      held_valid,
    output itp_item_t held_item
);

    logic      valid_reg;
    logic      valid_next;
    itp_item_t item_reg;
    logic      take;

    assign chr_stall = valid_reg && !advance;
    assign take      = chr_valid && !chr_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_in;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[rtl/itp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_core
// Token state register and combinational character step with result build.
// ----------------------------------------------------------------------------
`include "integer_token_parser_top_macros.svh"

module itp_core
    import itp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  itp_item_t   item,
    output logic        res_load,
    output itp_result_t res
);

    itp_state_t  state_reg;
    itp_state_t  state_next;
    itp_state_t  upd;

    logic        first;
    logic        tsigned;
    logic        take_minus;
    logic        is_prefix;
    logic        is_dec;
    logic        is_alpha;
    logic        dig_ok;
    logic [3:0]  dig;
    logic [35:0] mag_ext;
    logic [35:0] prod;
    logic [35:0] acc;
    logic        bad;
    logic [32:0] val;

    always_comb
    begin
        first      = (state_reg.position == 2'd0) && !state_reg.negative;
        tsigned    = first ? item.signed_mode : state_reg.token_signed;
        take_minus = first && tsigned && (item.ch == CH_MINUS);
        is_prefix  = (state_reg.position == 2'd1) && !state_reg.hex_base
                     && state_reg.digit_seen && (state_reg.magnitude == '0)
                     && ((item.ch == CH_LX) || (item.ch == CH_UX)) && !item.is_last;

        is_dec   = (item.ch >= CH_0) && (item.ch <= CH_9);
        is_alpha = (item.ch >= CH_A) && (item.ch <= CH_F);
        dig      = is_dec ? 4'(item.ch - CH_0) : 4'(4'(item.ch - CH_A) + HEX_ALPHA_BASE);
        // A-F only count in base 16
        dig_ok   = is_dec || (is_alpha && state_reg.hex_base);

        // x16 is a shift, x10 is x8 + x2
        mag_ext = {4'b0, state_reg.magnitude};
        prod    = state_reg.hex_base ? (mag_ext << 4) : ((mag_ext << 3) + (mag_ext << 1));
        acc     = prod + {32'b0, dig};

        upd              = state_reg;
        upd.token_signed = tsigned;
        if (take_minus)
        begin
            upd.negative = 1'b1;
        end
        else
        begin
            if (is_prefix)
            begin
                upd.hex_base   = 1'b1;
                upd.digit_seen = 1'b0;
            end
            else if (dig_ok)
            begin
                upd.magnitude  = acc[31:0];
                upd.digit_seen = 1'b1;
                if (|acc[35:32])
                begin
                    upd.error_seen = 1'b1;
                end
            end
            else
            begin
                upd.error_seen = 1'b1;
            end
            if (state_reg.position != POS_MAX)
            begin
                upd.position = 2'(state_reg.position + 2'd1);
            end
        end

        // Result from the updated state
        bad = upd.error_seen || !upd.digit_seen;
        val = {1'b0, upd.magnitude};
        if (upd.token_signed)
        begin
            if (upd.negative)
            begin
                if (upd.magnitude > INT32_MIN_MAG)
                begin
                    bad = 1'b1;
                end
                val = 33'(33'd0 - {1'b0, upd.magnitude});
            end
            else if (upd.magnitude > INT32_POS_MAG)
            begin
                bad = 1'b1;
            end
        end
        res.status = bad;
        res.value  = bad ? 33'sd0 : $signed(val);

        res_load   = advance && item.is_last;

        state_next = state_reg;
        if (advance)
        begin
            state_next = item.is_last ? itp_state_t'('0) : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ITP_ASSERT_NXT(a_clear_after_last, clk, rst_n, advance && item.is_last, state_reg == '0, "state not cleared after last character")
    `ITP_ASSERT_IMP(a_hex_pos, clk, rst_n, state_reg.hex_base, state_reg.position == 2'd2 || state_reg.position == POS_MAX, "hex base without prefix position")
    `ITP_ASSERT_IMP(a_neg_signed, clk, rst_n, state_reg.negative, state_reg.token_signed, "minus taken in unsigned token")

endmodule

[rtl/itp_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_out_stage
// Result register for the result channel.
// ----------------------------------------------------------------------------
module itp_out_stage
    import itp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  itp_result_t res_in,
    input  logic        res_stall,
    output logic        res_valid,
    output itp_result_t res_out
);

    logic        valid_reg;
    logic        valid_next;
    itp_result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign res_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

[rtl/integer_token_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_token_parser_top
// Parses a decimal or 0x-prefixed hex token, one character per transfer,
// into an int32 or uint32 value with a status flag.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  chr      | chr_valid / chr_stall | ch[7:0], is_last, signed_mode
//  res      | res_valid / res_stall | value[32:0] (signed), status
//
//  One character per cycle, sustained while no stalled result holds back a
//  last character; res_valid rises after the last character is transferred in
//  and passes the input register, then the result register.
//  The per-character step (x10 or x16 multiply-add plus range checks) sits
//  between the input register and the token state / result registers.
//  Reset clears the token state and both valid flags; no clearing pass.
//  A stalled result only holds back the next last character; other
//  characters keep flowing while the result waits.
// ----------------------------------------------------------------------------
`include "integer_token_parser_top_macros.svh"

module integer_token_parser_top
    import itp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               chr_valid,
    output logic               chr_stall,
    input  logic [7:0]         ch,
    input  logic               is_last,
    input  logic               signed_mode,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [32:0] value,
    output logic               status
);

    itp_item_t   item_in;
    itp_item_t   held_item;
    logic        held_valid;
    logic        advance;
    logic        res_load;
    itp_result_t core_res;
    itp_result_t res_out;

    assign item_in.ch          = ch;
    assign item_in.is_last     = is_last;
    assign item_in.signed_mode = signed_mode;

    // A held character moves on unless it ends a token and the result
    // register is still full and stalled.
    assign advance = held_valid && (!held_item.is_last || !res_valid || !res_stall);

    itp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .chr_valid  (chr_valid),
        .chr_stall  (chr_stall),
        .item_in    (item_in),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    itp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (held_item),
        .res_load (res_load),
        .res      (core_res)
    );

    itp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (core_res),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_out   (res_out)
    );

    assign value  = res_out.value;
    assign status = res_out.status;

    `ITP_ASSERT_IMP(a_err_value_zero, clk, rst_n, res_valid && status, value == 33'sd0, "error result carries nonzero value")
    `ITP_ASSERT_IMP(a_stall_needs_held, clk, rst_n, chr_stall, held_valid && held_item.is_last && res_valid, "input stalled without a blocked last character")
    `ITP_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_load, !res_valid || !res_stall, "result register overwritten while stalled")

endmodule
